// ===== hdl/cg_energy_error_termination_assert.svh =====
// ---------------------------------------------------------------------------
// CG energy error termination - assertion macros
// Concurrent checks on the module clock, idle while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef CG_ENERGY_ERROR_TERMINATION_ASSERT_SVH
`define CG_ENERGY_ERROR_TERMINATION_ASSERT_SVH

`ifndef SYNTHESIS
// cond holds at every clock edge out of reset
`define CGEE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cgee assertion failed");
// cons holds in the cycle after ante
`define CGEE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cgee assertion failed");
`else
`define CGEE_ASSERT(lbl, cond)
`define CGEE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/cgee_pkg.sv =====
// ---------------------------------------------------------------------------
// CG energy error termination - shared package
// Sizes, register indexes, control bundles and a saturating-add helper function.
// ---------------------------------------------------------------------------
package cgee_pkg;

  // Depth of the term history
  localparam int MAX_LA  = 16;
  localparam int RING_AW = (MAX_LA > 1) ? $clog2(MAX_LA) : 1;
  localparam int LA_W    = $clog2(MAX_LA + 1);

  // Step counter
  localparam int              CNT_W   = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = 17'd65536;

  // Configuration register indexes
  localparam logic [2:0] REG_REL_ACC   = 3'd0;
  localparam logic [2:0] REG_MACH_EPS  = 3'd1;
  localparam logic [2:0] REG_ABS_ACC   = 3'd2;
  localparam logic [2:0] REG_MIN_ACC   = 3'd3;
  localparam logic [2:0] REG_MAX_STEPS = 3'd4;
  localparam logic [2:0] REG_LOOK_AHD  = 3'd5;

  // One operation for the shared multiply-accumulate unit
  typedef struct packed {
    logic        vld;
    logic        clr;   // start a new sum
    logic [1:0]  sh;    // place the product at 32*sh
    logic [31:0] a;
    logic [31:0] b;
  } mac_op_t;

  // Term ring control
  typedef struct packed {
    logic               wr_en;
    logic [RING_AW-1:0] wr_idx;
    logic               rd_en;
    logic [RING_AW-1:0] rd_idx;
    logic               sum_clr;
  } ring_ctl_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

// ===== hdl/cgee_mac.sv =====
// ---------------------------------------------------------------------------
// CG energy error termination - shared multiply-accumulate unit
// 32x32 multiplier, registered, feeding a 128-bit placed accumulator.
// ---------------------------------------------------------------------------
module cgee_mac import cgee_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  mac_op_t       op,
  output logic [127:0]  acc
);

  logic [63:0]  prod_r;
  logic         vld_r;
  logic         clr_r;
  logic [1:0]   sh_r;
  logic [127:0] acc_r;
  logic [127:0] addend;

  // Stage 1: multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= op.vld;
    end
    prod_r <= {32'd0, op.a} * {32'd0, op.b};
    clr_r  <= op.clr;
    sh_r   <= op.sh;
  end

  // Stage 2: place and accumulate
  assign addend = {64'd0, prod_r} << {sh_r, 5'd0};

  always_ff @(posedge clk) begin
    if (vld_r) begin
      acc_r <= (clr_r ? 128'd0 : acc_r) + addend;
    end
  end

  assign acc = acc_r;

endmodule

// ===== hdl/cgee_ring.sv =====
// ---------------------------------------------------------------------------
// CG energy error termination - term ring and window sum
// Holds recent terms; sums the selected entries one per cycle, saturating.
// ---------------------------------------------------------------------------
module cgee_ring import cgee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ring_ctl_t   ctl,
  input  logic [63:0] wr_data,
  output logic [63:0] window_sum
);

  logic [63:0] ring_mem [MAX_LA];
  logic [63:0] rd_data_r;
  logic        rd_vld_r;
  logic [63:0] sum_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ring_mem[ctl.wr_idx] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= ring_mem[ctl.rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      sum_r    <= 64'd0;
    end else begin
      rd_vld_r <= ctl.rd_en;
      if (ctl.sum_clr) begin
        sum_r <= 64'd0;
      end else if (rd_vld_r) begin
        sum_r <= sat_add64(sum_r, rd_data_r);
      end
    end
  end

  assign window_sum = sum_r;

endmodule

// ===== hdl/cg_energy_error_termination.sv =====
// ---------------------------------------------------------------------------
// CG energy error termination
// Stopping test for conjugate gradients from a windowed energy error estimate.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  in_      slave      in_tvalid/in_tready  tdata: alpha, q_a_q, r_pinv_r
//                                           tuser: start_new
//  out_     master     out_tvalid/out_tready tdata: flags, steps_done
//  cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Each item runs the setup products, then the window sum of n terms,
//  n = min(look_ahead, steps recorded) <= 16 (one ring read a cycle), then
//  three 64x64 products on the single 32x32 multiplier, then posts the
//  result; the next item is accepted once the block is idle again.
//  Reset (rst_n low, synchronous) clears the history pointer, the energy,
//  the step counter and loads the register defaults; the ring needs no clear.
//  in_tready is low while an item is being worked; a result waiting at the
//  output does not hold off the next item, only the post of its own result.
//  cfg_ready is always high; write registers only while the block is idle.
//
`include "cg_energy_error_termination_assert.svh"

module cg_energy_error_termination import cgee_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] alpha, [63:32] q_a_q, [95:64] r_pinv_r
  input  logic [0:0]  in_tuser,   // [0] start_new
  // Result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] terminate, [1] vanishing_step,
                                  // [2] minimal_decrease, [19:3] steps_done, [23:20] zero
  // Register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_SUM  = 5'b00100,
    ST_WIDE = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // Step numbers inside the setup and wide-product phases
  localparam logic [3:0] PREP_TERM = 4'd2;   // term lands in the accumulator
  localparam logic [3:0] PREP_TSQ  = 4'd3;
  localparam logic [3:0] PREP_MSQ  = 4'd4;
  localparam logic [3:0] PREP_ABS2 = 4'd5;
  localparam logic [3:0] PREP_LAST = 4'd6;   // eps^2 lands
  localparam logic [3:0] WIDE_OPS  = 4'd12;  // three products of four parts
  localparam logic [3:0] WIDE_TERM = 4'd5;   // tol^2 * energy complete
  localparam logic [3:0] WIDE_MDEC = 4'd9;   // min^2 * energy complete
  localparam logic [3:0] WIDE_LAST = 4'd13;  // eps^2 * energy complete

  // Configuration registers
  logic [31:0] rel_acc_r, mach_eps_r, abs_acc_r, min_acc_r;
  logic [15:0] max_steps_r;
  logic [4:0]  look_ahead_r;

  // Sequencer
  state_t            state_r, state_nxt;
  logic [3:0]        step_r, step_nxt;
  logic [LA_W-1:0]   sum_left_r, sum_left_nxt;

  // Item and history state
  logic [31:0]        alpha_r, rpr_r, step_len_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [RING_AW-1:0] ptr_r, rd_idx_r;
  logic [63:0]        energy_r;
  logic [63:0]        tsq_r, msq_r, abs2_r, eps2_r;
  logic               term_flag_r, vanish_r, mindec_r;

  // Output register
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [19:0]        out_data_r;

  // Datapath wiring
  logic               in_acc;
  logic               start_new;
  logic [31:0]        q_raw, tol;
  logic [CNT_W-1:0]   la_c, n_c, look_ext, max_ext;
  mac_op_t            mac_op;
  logic [127:0]       mac_acc;
  ring_ctl_t          ring_ctl;
  logic [63:0]        window_sum;
  logic [127:0]       wide_lhs;
  logic               wide_lt, e_nz, out_load;
  logic [31:0]        wide_x_lo, wide_x_hi;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign start_new = in_tuser[0];
  assign q_raw     = in_tdata[63:32];

  // ---------------------------------------------------------------------
  // Register writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_acc_r    <= 32'd66;
      mach_eps_r   <= 32'd1;
      abs_acc_r    <= 32'd1;
      min_acc_r    <= 32'd3277;
      max_steps_r  <= 16'd1000;
      look_ahead_r <= 5'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REL_ACC:   rel_acc_r    <= cfg_data;
        REG_MACH_EPS:  mach_eps_r   <= cfg_data;
        REG_ABS_ACC:   abs_acc_r    <= cfg_data;
        REG_MIN_ACC:   min_acc_r    <= cfg_data;
        REG_MAX_STEPS: max_steps_r  <= cfg_data[15:0];
        REG_LOOK_AHD:  look_ahead_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Derived values: tolerance, clamped look-ahead, window length
  // ---------------------------------------------------------------------
  assign tol      = (rel_acc_r > mach_eps_r) ? rel_acc_r : mach_eps_r;
  assign look_ext = {{(CNT_W-5){1'b0}}, look_ahead_r};
  assign max_ext  = {{(CNT_W-16){1'b0}}, max_steps_r};
  assign la_c     = (look_ext > CNT_W'(MAX_LA)) ? CNT_W'(MAX_LA) : look_ext;
  assign n_c      = (la_c < cnt_r) ? la_c : cnt_r;
  assign e_nz     = |energy_r;

  // Saturating step count, restarted by start_new
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      if (start_new) begin
        cnt_nxt = CNT_W'(1);
      end else if (cnt_r < CNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Multiplier schedule
  //   setup: alpha*r, tol^2, min^2, abs^2, eps^2 (each lands via the product and accumulator registers)
  //   wide:  tol^2*E, min^2*E, eps^2*E, four 32x32 parts each
  // ---------------------------------------------------------------------
  always_comb begin
    unique case (step_r[3:2])
      2'd0:    begin wide_x_lo = tsq_r[31:0];  wide_x_hi = tsq_r[63:32];  end
      2'd1:    begin wide_x_lo = msq_r[31:0];  wide_x_hi = msq_r[63:32];  end
      default: begin wide_x_lo = eps2_r[31:0]; wide_x_hi = eps2_r[63:32]; end
    endcase
  end

  always_comb begin
    mac_op = '0;
    if (state_r == ST_PREP) begin
      mac_op.clr = 1'b1;
      unique case (step_r)
        4'd0:    begin mac_op.vld = 1'b1; mac_op.a = alpha_r;    mac_op.b = rpr_r;      end
        4'd1:    begin mac_op.vld = 1'b1; mac_op.a = tol;        mac_op.b = tol;        end
        4'd2:    begin mac_op.vld = 1'b1; mac_op.a = min_acc_r;  mac_op.b = min_acc_r;  end
        4'd3:    begin mac_op.vld = 1'b1; mac_op.a = abs_acc_r;  mac_op.b = abs_acc_r;  end
        4'd4:    begin mac_op.vld = 1'b1; mac_op.a = mach_eps_r; mac_op.b = mach_eps_r; end
        default: mac_op.vld = 1'b0;
      endcase
    end else if (state_r == ST_WIDE && step_r < WIDE_OPS) begin
      mac_op.vld = 1'b1;
      mac_op.clr = (step_r[1:0] == 2'd0);
      mac_op.sh  = {1'b0, step_r[1]} + {1'b0, step_r[0]};
      mac_op.a   = step_r[1] ? wide_x_hi : wide_x_lo;
      mac_op.b   = step_r[0] ? energy_r[63:32] : energy_r[31:0];
    end
  end

  cgee_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .acc   (mac_acc)
  );

  // ---------------------------------------------------------------------
  // Term ring: write the new term, then read back the window newest first
  // ---------------------------------------------------------------------
  always_comb begin
    ring_ctl         = '0;
    ring_ctl.wr_en   = (state_r == ST_PREP) && (step_r == PREP_TERM);
    ring_ctl.wr_idx  = ptr_r;
    ring_ctl.sum_clr = ring_ctl.wr_en;
    ring_ctl.rd_en   = (state_r == ST_SUM);
    ring_ctl.rd_idx  = rd_idx_r;
  end

  cgee_ring u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ring_ctl),
    .wr_data    (mac_acc[63:0]),
    .window_sum (window_sum)
  );

  // Ratio tests compare W*2^32 (or step*2^48) against the finished product
  assign wide_lhs = (step_r == WIDE_LAST) ? {48'd0, step_len_r, 48'd0}
                                          : {32'd0, window_sum, 32'd0};
  assign wide_lt  = wide_lhs < mac_acc;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign out_load = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    sum_left_nxt = sum_left_r;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = 4'd0;
        if (in_acc) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        step_nxt = step_r + 1'b1;
        if (step_r == PREP_LAST) begin
          step_nxt     = 4'd0;
          sum_left_nxt = n_c[LA_W-1:0];
          state_nxt    = (n_c == '0) ? ST_WIDE : ST_SUM;
        end
      end
      ST_SUM: begin
        sum_left_nxt = sum_left_r - 1'b1;
        if (sum_left_r == LA_W'(1)) begin
          state_nxt = ST_WIDE;
        end
      end
      ST_WIDE: begin
        step_nxt = step_r + 1'b1;
        if (step_r == WIDE_LAST) begin
          step_nxt  = 4'd0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= 4'd0;
      sum_left_r   <= '0;
      cnt_r        <= '0;
      ptr_r        <= '0;
      energy_r     <= 64'd0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      sum_left_r   <= sum_left_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      // start_new drops the history before this item's term goes in
      if (in_acc && start_new) begin
        ptr_r    <= '0;
        energy_r <= 64'd0;
      end else if (ring_ctl.wr_en) begin
        ptr_r    <= (ptr_r == RING_AW'(MAX_LA - 1)) ? '0 : ptr_r + 1'b1;
        energy_r <= sat_add64(energy_r, mac_acc[63:0]);
      end
    end
  end

  // Payload: operands, squared tolerances, flags
  always_ff @(posedge clk) begin
    if (in_acc) begin
      alpha_r    <= in_tdata[31:0];
      rpr_r      <= in_tdata[95:64];
      // magnitude of q'Aq; the most negative value maps to 2^31
      step_len_r <= q_raw[31] ? (~q_raw + 32'd1) : q_raw;
    end
    if (state_r == ST_PREP) begin
      if (step_r == PREP_TERM) rd_idx_r <= ptr_r;
      if (step_r == PREP_TSQ)  tsq_r    <= mac_acc[63:0];
      if (step_r == PREP_MSQ)  msq_r    <= mac_acc[63:0];
      if (step_r == PREP_ABS2) abs2_r   <= mac_acc[63:0];
      if (step_r == PREP_LAST) eps2_r   <= mac_acc[63:0];
    end
    if (state_r == ST_SUM) begin
      // walk back from the newest term
      rd_idx_r <= (rd_idx_r == '0) ? RING_AW'(MAX_LA - 1) : rd_idx_r - 1'b1;
    end
    if (state_r == ST_WIDE) begin
      if (step_r == WIDE_TERM) begin
        term_flag_r <= (cnt_r > max_ext) || ((cnt_r > la_c) && e_nz && wide_lt);
      end
      if (step_r == WIDE_MDEC) begin
        mindec_r <= (cnt_r >= la_c) && e_nz && wide_lt;
      end
      if (step_r == WIDE_LAST) begin
        // short step first; against energy only when energy exceeds abs^2
        vanish_r <= ({16'd0, step_len_r, 16'd0} < abs2_r) &&
                    (!(energy_r > abs2_r) || wide_lt);
      end
    end
    if (out_load) begin
      out_data_r <= {cnt_r, mindec_r, vanish_r, term_flag_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_data_r};

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `CGEE_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready)
  `CGEE_ASSERT_NEXT(a_restart_count, in_acc && start_new, cnt_r == CNT_W'(1))
  `CGEE_ASSERT(a_sum_nonempty, (state_r != ST_SUM) || (sum_left_r != '0))
  `CGEE_ASSERT(a_count_limit, cnt_r <= CNT_MAX)

endmodule
